/* rtl/uft_pkg.sv */
// Shared types and constants for the UTF-8 accent-folding tokenizer.
// Used by uft_decode and utf8_fold_tokenizer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package uft_pkg;

  localparam int ACCUM_W = 21;
  localparam int RES_MAX = 6;
  localparam int RES_CNT_W = 3;

  localparam logic [1:0] KIND_BYTE       = 2'd0;
  localparam logic [1:0] KIND_TOKEN_END  = 2'd1;
  localparam logic [1:0] KIND_STRING_END = 2'd2;

  // decoder state carried between words
  typedef struct packed {
    logic [ACCUM_W-1:0] accum;
    logic [1:0]         pend;
    logic [1:0]         seq;
    logic               tok;
    logic               err;
  } dec_state_t;

  // one result word
  typedef struct packed {
    logic       bad;
    logic [1:0] kind;
    logic [7:0] data;
  } res_t;

  typedef res_t [RES_MAX-1:0] res_run_t;

endpackage

`default_nettype wire

/* rtl/uft_decode.sv */
// UTF-8 decode, accent fold, re-encode and token split for one input byte.
// Purely combinational; uses uft_pkg types and constants.
`timescale 1ns / 1ps
`default_nettype none

module uft_decode (
  input  wire uft_pkg::dec_state_t st,
  input  wire logic [7:0]          in_byte,
  input  wire logic                in_last,
  output uft_pkg::dec_state_t      st_next,
  output uft_pkg::res_run_t        res,
  output logic [uft_pkg::RES_CNT_W-1:0] res_cnt
);

  localparam logic [7:0] CHR_A = 8'h61;
  localparam logic [7:0] CHR_E = 8'h65;
  localparam logic [7:0] CHR_O = 8'h6F;

  function automatic logic is_sep(input logic [7:0] b);
    is_sep = (b <= 8'h20) || (b == 8'h2C) || (b == 8'h3B) || (b == 8'h2F) ||
             (b == 8'h7C) || (b == 8'h28) || (b == 8'h29) || (b == 8'h2E) ||
             (b == 8'h25) || (b == 8'h5F);
  endfunction

  function automatic logic [uft_pkg::ACCUM_W-1:0] fold(
    input logic [uft_pkg::ACCUM_W-1:0] cp
  );
    localparam int W = uft_pkg::ACCUM_W;
    if ((cp >= W'('hC0) && cp <= W'('hC5)) || (cp >= W'('hE0) && cp <= W'('hE5)) ||
        (cp >= W'('h100) && cp <= W'('h105)))
      fold = W'('h61);
    else if (cp == W'('hC7) || cp == W'('hE7) || (cp >= W'('h106) && cp <= W'('h109)) ||
             cp == W'('h10C) || cp == W'('h10D))
      fold = W'('h63);
    else if ((cp >= W'('hC8) && cp <= W'('hCB)) || (cp >= W'('hE8) && cp <= W'('hEB)) ||
             (cp >= W'('h112) && cp <= W'('h11B)))
      fold = W'('h65);
    else if ((cp >= W'('hCC) && cp <= W'('hCF)) || (cp >= W'('hEC) && cp <= W'('hEF)) ||
             cp == W'('h12A) || cp == W'('h12B) || cp == W'('h12E) || cp == W'('h12F))
      fold = W'('h69);
    else if (cp == W'('hD1) || cp == W'('hF1) || cp == W'('h143) || cp == W'('h144) ||
             cp == W'('h147) || cp == W'('h148))
      fold = W'('h6E);
    else if ((cp >= W'('hD2) && cp <= W'('hD6)) || (cp >= W'('hF2) && cp <= W'('hF6)) ||
             (cp >= W'('h14C) && cp <= W'('h151)))
      fold = W'('h6F);
    else if ((cp >= W'('hD9) && cp <= W'('hDC)) || (cp >= W'('hF9) && cp <= W'('hFC)) ||
             (cp >= W'('h16A) && cp <= W'('h171)))
      fold = W'('h75);
    else if (cp == W'('hDD) || cp == W'('hFD) || cp == W'('hFF) || cp == W'('h178))
      fold = W'('h79);
    else if (cp >= W'('h41) && cp <= W'('h5A))
      fold = cp + W'('h20);
    else
      fold = cp;
  endfunction

  logic                        cont;
  logic                        cp_valid;
  logic                        cp_bad;
  logic [uft_pkg::ACCUM_W-1:0] cp;
  logic [uft_pkg::ACCUM_W-1:0] acc_sh;
  logic [uft_pkg::ACCUM_W-1:0] f;
  logic [7:0]                  bytes [4];
  logic [2:0]                  nb;
  logic                        te;
  logic                        se;
  uft_pkg::dec_state_t         s;

  assign cont   = (in_byte[7:6] == 2'b10);
  assign acc_sh = {st.accum[uft_pkg::ACCUM_W-7:0], in_byte[5:0]};
  assign f      = fold(cp);

  always_comb begin
    s        = st;
    cp_valid = 1'b0;
    cp_bad   = 1'b0;
    cp       = '0;
    if (st.pend == 2'd0 || !cont) begin
      if (st.pend != 2'd0) begin
        // sequence cut short: drop it and restart on this byte
        s.err   = 1'b1;
        s.accum = '0;
        s.seq   = 2'd0;
        s.pend  = 2'd0;
      end
      if (in_byte < 8'h80) begin
        cp_valid = 1'b1;
        cp       = {13'd0, in_byte};
      end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
        s.accum = {16'd0, in_byte[4:0]};
        s.pend  = 2'd1;
        s.seq   = 2'd1;
      end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
        s.accum = {17'd0, in_byte[3:0]};
        s.pend  = 2'd2;
        s.seq   = 2'd2;
      end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
        s.accum = {18'd0, in_byte[2:0]};
        s.pend  = 2'd3;
        s.seq   = 2'd3;
      end else begin
        s.err = 1'b1;
      end
    end else begin
      s.pend = st.pend - 2'd1;
      if (st.pend == 2'd1) begin
        cp_bad = (st.seq == 2'd2 && acc_sh < 21'h800) ||
                 (st.seq == 2'd3 && (acc_sh < 21'h10000 || acc_sh > 21'h10FFFF)) ||
                 (acc_sh >= 21'hD800 && acc_sh <= 21'hDFFF);
        s.seq   = 2'd0;
        s.accum = '0;
        if (cp_bad) begin
          s.err = 1'b1;
        end else begin
          cp_valid = 1'b1;
          cp       = acc_sh;
        end
      end else begin
        s.accum = acc_sh;
      end
    end
  end

  // code point to token bytes
  always_comb begin
    st_next  = s;
    bytes[0] = '0;
    bytes[1] = '0;
    bytes[2] = '0;
    bytes[3] = '0;
    nb       = 3'd0;
    te       = 1'b0;
    se       = 1'b0;
    if (cp_valid) begin
      if (cp == 21'h152 || cp == 21'h153) begin
        bytes[0] = CHR_O;
        bytes[1] = CHR_E;
        nb = 3'd2;
        st_next.tok = 1'b1;
      end else if (cp == 21'hC6 || cp == 21'hE6) begin
        bytes[0] = CHR_A;
        bytes[1] = CHR_E;
        nb = 3'd2;
        st_next.tok = 1'b1;
      end else if (f < 21'h80) begin
        if (is_sep(f[7:0])) begin
          te = s.tok;
          st_next.tok = 1'b0;
        end else begin
          bytes[0] = f[7:0];
          nb = 3'd1;
          st_next.tok = 1'b1;
        end
      end else if (f < 21'h800) begin
        bytes[0] = {3'b110, f[10:6]};
        bytes[1] = {2'b10, f[5:0]};
        nb = 3'd2;
        st_next.tok = 1'b1;
      end else if (f < 21'h10000) begin
        bytes[0] = {4'b1110, f[15:12]};
        bytes[1] = {2'b10, f[11:6]};
        bytes[2] = {2'b10, f[5:0]};
        nb = 3'd3;
        st_next.tok = 1'b1;
      end else begin
        bytes[0] = {5'b11110, f[20:18]};
        bytes[1] = {2'b10, f[17:12]};
        bytes[2] = {2'b10, f[11:6]};
        bytes[3] = {2'b10, f[5:0]};
        nb = 3'd4;
        st_next.tok = 1'b1;
      end
    end
    if (in_last) begin
      se = 1'b1;
      if (st_next.pend != 2'd0) st_next.err = 1'b1;
      if (st_next.tok) te = 1'b1;
    end
    for (int k = 0; k < uft_pkg::RES_MAX; k++) begin
      if (3'(k) < nb) begin
        res[k].data = bytes[2'(k)];
        res[k].kind = uft_pkg::KIND_BYTE;
        res[k].bad  = 1'b0;
      end else if (3'(k) == nb && te) begin
        res[k].data = '0;
        res[k].kind = uft_pkg::KIND_TOKEN_END;
        res[k].bad  = 1'b0;
      end else begin
        res[k].data = '0;
        res[k].kind = uft_pkg::KIND_STRING_END;
        res[k].bad  = st_next.err;
      end
    end
    res_cnt = nb + {2'd0, te} + {2'd0, se};
    if (in_last) st_next = '0;
  end

endmodule

`default_nettype wire

/* rtl/utf8_fold_tokenizer.sv */
// Accent-folding UTF-8 tokenizer, top level: input register, decoder, result run buffer.
// Depends on uft_pkg and uft_decode.
// Path: input register, then decoder, then run buffer; a byte's results are driven from the run buffer.
// Throughput: one byte per cycle while the output is ready and each byte gives at most one
// result; a byte giving more results (up to six) stalls further input until the run buffer drains.
// Reset (rst, synchronous): empties input register and run buffer, clears decoder state.
`timescale 1ns / 1ps
`default_nettype none

module utf8_fold_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // [7:0] in_byte
  input  wire logic       s_axis_tlast,  // string_last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
  output logic [2:0]      m_axis_tuser,  // [1:0] kind, [2] bad_utf8
  output logic            m_axis_tlast   // run_last
);

  logic                           in_valid;
  logic [7:0]                     in_byte;
  logic                           in_last;
  uft_pkg::dec_state_t            st;
  uft_pkg::dec_state_t            st_next;
  uft_pkg::res_run_t              run;
  uft_pkg::res_run_t              run_next;
  logic [uft_pkg::RES_CNT_W-1:0]  run_cnt;
  logic [uft_pkg::RES_CNT_W-1:0]  run_cnt_next;
  logic [uft_pkg::RES_CNT_W-1:0]  run_ptr;
  logic                           run_tail;
  logic                           run_done;
  logic                           in_consume;

  uft_decode u_decode (
    .st      (st),
    .in_byte (in_byte),
    .in_last (in_last),
    .st_next (st_next),
    .res     (run_next),
    .res_cnt (run_cnt_next)
  );

  assign m_axis_tvalid = (run_ptr != run_cnt);
  assign run_tail      = (run_ptr == run_cnt - 3'd1);
  assign run_done      = !m_axis_tvalid || (m_axis_tready && run_tail);
  assign in_consume    = in_valid && run_done;
  assign s_axis_tready = !in_valid || in_consume;

  assign m_axis_tdata  = run[run_ptr].data;
  assign m_axis_tuser  = {run[run_ptr].bad, run[run_ptr].kind};
  assign m_axis_tlast  = run_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= '0;
      run_cnt <= '0;
      run_ptr <= '0;
    end else if (in_consume) begin
      st      <= st_next;
      run_cnt <= run_cnt_next;
      run_ptr <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      run_ptr <= run_ptr + 3'd1;
    end
    if (in_consume) begin
      run <= run_next;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/utf8_fold_tokenizer_tb.sv */
// Self-checking testbench for utf8_fold_tokenizer: directed table then random strings,
// each accepted byte run through an in-bench fold/tokenize predictor, results compared in order.
// Depends on uft_pkg and the utf8_fold_tokenizer RTL.
`timescale 1ns / 1ps

module utf8_fold_tokenizer_tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 250;
  localparam int RANDOM_BYTES = 144;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    logic [7:0] w_data;
    logic [1:0] w_kind;
    logic       w_bad;
  } stim_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       bad;
    logic       last;
  } word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  stim_t stim_q[$];
  word_t fold_run[$];
  word_t expect_q[$];

  // predictor state
  logic [uft_pkg::ACCUM_W-1:0] cp_accum;
  logic [1:0]                  cont_left;
  logic [1:0]                  cont_total;
  logic                        tok_open;
  logic                        utf_err;

  int fails = 0;
  int words_sent = 0;
  int accept_idx = 0;
  int idle_cycles = 0;
  int n_results = 0;
  int n_tok_ends = 0;
  int n_strings = 0;
  int n_flagged = 0;

  always #4 clk = ~clk;

  utf8_fold_tokenizer dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // ---------------- queue helpers ----------------

  function automatic void queue_stim(input stim_t s);
    stim_q = {stim_q, s};
  endfunction

  function automatic void queue_expect(input word_t w);
    expect_q = {expect_q, w};
  endfunction

  // ---------------- predictor ----------------

  function automatic void clear_fold_state();
    cp_accum = '0;
    cont_left = 2'd0;
    cont_total = 2'd0;
    tok_open = 1'b0;
    utf_err = 1'b0;
  endfunction

  function automatic void emit(input logic [7:0] data, input logic [1:0] kind,
                               input logic bad);
    word_t w;
    w.data = data;
    w.kind = kind;
    w.bad = bad;
    w.last = 1'b0;
    fold_run = {fold_run, w};
  endfunction

  function automatic bit is_delim(input logic [7:0] b);
    return b <= 8'h20 || b == "," || b == ";" || b == "/" || b == "|" || b == "(" ||
           b == ")" || b == "." || b == "%" || b == "_";
  endfunction

  function automatic void tokenize(input logic [7:0] b);
    if (is_delim(b)) begin
      if (tok_open) begin
        emit(8'h00, uft_pkg::KIND_TOKEN_END, 1'b0);
        tok_open = 1'b0;
      end
    end else begin
      emit(b, uft_pkg::KIND_BYTE, 1'b0);
      tok_open = 1'b1;
    end
  endfunction

  function automatic logic [20:0] fold_cp(input logic [20:0] cp);
    if ((cp >= 21'hC0 && cp <= 21'hC5) || (cp >= 21'hE0 && cp <= 21'hE5) ||
        (cp >= 21'h100 && cp <= 21'h105))
      return "a";
    if (cp == 21'hC7 || cp == 21'hE7 || (cp >= 21'h106 && cp <= 21'h109) ||
        cp == 21'h10C || cp == 21'h10D)
      return "c";
    if ((cp >= 21'hC8 && cp <= 21'hCB) || (cp >= 21'hE8 && cp <= 21'hEB) ||
        (cp >= 21'h112 && cp <= 21'h11B))
      return "e";
    if ((cp >= 21'hCC && cp <= 21'hCF) || (cp >= 21'hEC && cp <= 21'hEF) ||
        cp == 21'h12A || cp == 21'h12B || cp == 21'h12E || cp == 21'h12F)
      return "i";
    if (cp == 21'hD1 || cp == 21'hF1 || cp == 21'h143 || cp == 21'h144 ||
        cp == 21'h147 || cp == 21'h148)
      return "n";
    if ((cp >= 21'hD2 && cp <= 21'hD6) || (cp >= 21'hF2 && cp <= 21'hF6) ||
        (cp >= 21'h14C && cp <= 21'h151))
      return "o";
    if ((cp >= 21'hD9 && cp <= 21'hDC) || (cp >= 21'hF9 && cp <= 21'hFC) ||
        (cp >= 21'h16A && cp <= 21'h171))
      return "u";
    if (cp == 21'hDD || cp == 21'hFD || cp == 21'hFF || cp == 21'h178)
      return "y";
    if (cp >= "A" && cp <= "Z")
      return cp + 21'h20;
    return cp;
  endfunction

  function automatic void fold_and_encode(input logic [20:0] cp_in);
    logic [20:0] cp;
    if (cp_in == 21'h152 || cp_in == 21'h153) begin
      tokenize("o");
      tokenize("e");
      return;
    end
    if (cp_in == 21'hC6 || cp_in == 21'hE6) begin
      tokenize("a");
      tokenize("e");
      return;
    end
    cp = fold_cp(cp_in);
    if (cp < 21'h80) begin
      tokenize(cp[7:0]);
    end else if (cp < 21'h800) begin
      tokenize({3'b110, cp[10:6]});
      tokenize({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      tokenize({4'b1110, cp[15:12]});
      tokenize({2'b10, cp[11:6]});
      tokenize({2'b10, cp[5:0]});
    end else begin
      tokenize({5'b11110, cp[20:18]});
      tokenize({2'b10, cp[17:12]});
      tokenize({2'b10, cp[11:6]});
      tokenize({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void open_seq(input logic [7:0] b);
    if (b < 8'h80) begin
      fold_and_encode({13'd0, b});
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      cp_accum = {16'd0, b[4:0]};
      cont_left = 2'd1;
      cont_total = 2'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      cp_accum = {17'd0, b[3:0]};
      cont_left = 2'd2;
      cont_total = 2'd2;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      cp_accum = {18'd0, b[2:0]};
      cont_left = 2'd3;
      cont_total = 2'd3;
    end else begin
      utf_err = 1'b1;
    end
  endfunction

  function automatic void decode_octet(input logic [7:0] b);
    logic [20:0] cp;
    logic        bad;
    if (cont_left == 2'd0) begin
      open_seq(b);
      return;
    end
    if (b[7:6] != 2'b10) begin
      utf_err = 1'b1;
      cont_left = 2'd0;
      cont_total = 2'd0;
      cp_accum = '0;
      open_seq(b);
      return;
    end
    cp_accum = {cp_accum[14:0], b[5:0]};
    cont_left = cont_left - 2'd1;
    if (cont_left != 2'd0)
      return;
    cp = cp_accum;
    bad = (cont_total == 2'd2 && cp < 21'h800) ||
          (cont_total == 2'd3 && (cp < 21'h10000 || cp > 21'h10FFFF)) ||
          (cp >= 21'hD800 && cp <= 21'hDFFF);
    cont_total = 2'd0;
    cp_accum = '0;
    if (bad)
      utf_err = 1'b1;
    else
      fold_and_encode(cp);
  endfunction

  // fills fold_run with the words one input byte gives
  function automatic void predict_octet(input logic [7:0] b, input logic last);
    fold_run.delete();
    decode_octet(b);
    if (last) begin
      if (cont_left != 2'd0)
        utf_err = 1'b1;
      if (tok_open)
        emit(8'h00, uft_pkg::KIND_TOKEN_END, 1'b0);
      emit(8'h00, uft_pkg::KIND_STRING_END, utf_err);
      clear_fold_state();
    end
    if (fold_run.size() > 0)
      fold_run[fold_run.size()-1].last = 1'b1;
  endfunction

  // ---------------- stimulus generation ----------------

  function automatic void add_octet(input logic [7:0] b);
    stim_t s;
    s = '0;
    s.b = b;
    queue_stim(s);
  endfunction

  function automatic void add_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_octet(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_octet({3'b110, cp[10:6]});
      add_octet({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_octet({4'b1110, cp[15:12]});
      add_octet({2'b10, cp[11:6]});
      add_octet({2'b10, cp[5:0]});
    end else begin
      add_octet({5'b11110, cp[20:18]});
      add_octet({2'b10, cp[17:12]});
      add_octet({2'b10, cp[11:6]});
      add_octet({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void add_broken();
    int v;
    case ($urandom_range(0, 6))
      0: add_octet(8'(8'h80 + $urandom_range(0, 63)));
      1: begin
        v = $urandom_range(0, 12);
        add_octet(v < 2 ? 8'(8'hC0 + v) : 8'(8'hF3 + v));
      end
      2: begin
        add_octet(8'(8'hC2 + $urandom_range(0, 29)));
        add_cp(21'($urandom_range(8'h21, 8'h7E)));
      end
      3: begin
        add_octet(8'hE0);
        add_octet(8'(8'h80 + $urandom_range(0, 31)));
        add_octet(8'(8'h80 + $urandom_range(0, 63)));
      end
      4: begin
        add_octet(8'hED);
        add_octet(8'(8'hA0 + $urandom_range(0, 31)));
        add_octet(8'(8'h80 + $urandom_range(0, 63)));
      end
      5: begin
        add_octet(8'hF4);
        add_octet(8'(8'h90 + $urandom_range(0, 47)));
        add_octet(8'(8'h80 + $urandom_range(0, 63)));
        add_octet(8'(8'h80 + $urandom_range(0, 63)));
      end
      default: add_octet(8'($urandom_range(0, 255)));
    endcase
  endfunction

  function automatic void add_string();
    int    n;
    int    k;
    int    sel;
    string seps;
    seps = ",;/|().%_ ";
    n = $urandom_range(1, 8);
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 22)
        add_cp(21'($urandom_range(0, 127)));
      else if (sel < 38)
        add_cp(21'("A" + $urandom_range(0, 25)));
      else if (sel < 52)
        add_cp(21'($urandom_range(8'h80, 8'hFF)));
      else if (sel < 64)
        add_cp(21'($urandom_range(21'h100, 21'h17F)));
      else if (sel < 69)
        case ($urandom_range(0, 3))
          0: add_cp(21'h152);
          1: add_cp(21'h153);
          2: add_cp(21'hC6);
          default: add_cp(21'hE6);
        endcase
      else if (sel < 77)
        add_cp(21'($urandom_range(21'h800, 21'hFFFF)));
      else if (sel < 83)
        add_cp(21'($urandom_range(21'h10000, 21'h10FFFF)));
      else if (sel < 90)
        add_cp({13'd0, seps[$urandom_range(0, 9)]});
      else
        add_broken();
    end
    // lead byte left unfinished at the string end
    if ($urandom_range(0, 7) == 0)
      add_octet(8'(8'hC2 + $urandom_range(0, 50)));
    stim_q[stim_q.size()-1].last = 1'b1;
  endfunction

  function automatic int pick_gap(input int idx);
    int r;
    if (idx % 40 >= 28)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------- checking ----------------

  function automatic void note_fail(input string what, input word_t want, input word_t got);
    fails++;
    if (fails <= 10)
      $display({"[%0t] %s: expected data %02h kind %0d bad %0d last %0d,",
                " got data %02h kind %0d bad %0d last %0d"},
               $realtime, what, want.data, want.kind, want.bad, want.last,
               got.data, got.kind, got.bad, got.last);
  endfunction

  always @(posedge clk) begin : monitor
    stim_t item;
    word_t got;
    word_t want;
    int    k;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        item = stim_q[accept_idx];
        accept_idx++;
        predict_octet(item.b, item.last);
        if (item.typed) begin
          want.data = item.w_data;
          want.kind = item.w_kind;
          want.bad = item.w_bad;
          want.last = 1'b1;
          queue_expect(want);
        end else begin
          for (k = 0; k < fold_run.size(); k++)
            queue_expect(fold_run[k]);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.data = m_axis_tdata;
        got.kind = m_axis_tuser[1:0];
        got.bad = m_axis_tuser[2];
        got.last = m_axis_tlast;
        n_results++;
        if (got.kind == uft_pkg::KIND_TOKEN_END)
          n_tok_ends++;
        if (got.kind == uft_pkg::KIND_STRING_END) begin
          n_strings++;
          if (got.bad)
            n_flagged++;
        end
        if (expect_q.size() == 0) begin
          note_fail("unexpected word", '0, got);
        end else begin
          want = expect_q.pop_front();
          if (got.data !== want.data)
            note_fail("out_byte mismatch", want, got);
          else if (got.kind !== want.kind)
            note_fail("kind mismatch", want, got);
          else if (got.bad !== want.bad)
            note_fail("bad_utf8 mismatch", want, got);
          else if (got.last !== want.last)
            note_fail("run_last mismatch", want, got);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $realtime, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------- output side ----------------

  initial begin : sink
    int r;
    int calm_left;
    bit held;
    calm_left = 0;
    held = 0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && words_sent >= 60) begin
        // long back-pressure: input must stall while the run buffer is full
        held = 1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm_left > 0) begin
        calm_left--;
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          calm_left = $urandom_range(40, 80);
          m_axis_tready <= 1'b1;
          @(posedge clk);
        end else if (r < 70) begin
          m_axis_tready <= 1'b1;
          @(posedge clk);
        end else if (r < 95) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(10, 30)) @(posedge clk);
        end
      end
    end
  end

  // ---------------- input side and run control ----------------

  initial begin : source
    stim_t dir_tab [26];
    int    i;
    int    gap;
    int    n_dir;
    clear_fold_state();
    dir_tab = '{
      '{8'h20, 1'b1, 1'b1, 8'h00, uft_pkg::KIND_STRING_END, 1'b0}, // empty string after reset
      '{8'h41, 1'b0, 1'b1, 8'h61, uft_pkg::KIND_BYTE, 1'b0},       // upper case folds
      '{8'h7A, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},
      '{8'hC3, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},       // E acute
      '{8'h89, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},
      '{8'hC5, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},       // oe ligature
      '{8'h93, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},
      '{8'hC3, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},       // ae ligature
      '{8'hA6, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},
      '{8'h2C, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},       // delimiter closes token
      '{8'h00, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},       // NUL
      '{8'hE2, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},       // euro sign passes
      '{8'h82, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},
      '{8'hAC, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},
      '{8'hF0, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},       // 4-byte point, longest run
      '{8'h9F, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},
      '{8'h98, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},
      '{8'h80, 1'b1, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},
      '{8'h80, 1'b1, 1'b1, 8'h00, uft_pkg::KIND_STRING_END, 1'b1}, // stray continuation
      '{8'hFF, 1'b1, 1'b1, 8'h00, uft_pkg::KIND_STRING_END, 1'b1}, // invalid lead
      '{8'hED, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},       // surrogate
      '{8'hA0, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},
      '{8'h80, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},
      '{8'hC3, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},       // cut short
      '{8'h7F, 1'b0, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0},
      '{8'hE2, 1'b1, 1'b0, 8'h00, uft_pkg::KIND_BYTE, 1'b0}        // unfinished at end
    };
    for (i = 0; i < 26; i++)
      queue_stim(dir_tab[i]);
    n_dir = stim_q.size();
    while (stim_q.size() - n_dir < RANDOM_BYTES)
      add_string();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < stim_q.size(); i++) begin
      gap = pick_gap(i);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= stim_q[i].b;
      s_axis_tlast <= stim_q[i].last;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      words_sent++;
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    while (expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expect_q.size() != 0) begin
      fails += expect_q.size();
      $display("%0d expected words never arrived", expect_q.size());
    end

    $display("Run covered %0d input bytes in %0d strings (%0d flagged malformed),",
             words_sent, n_strings, n_flagged);
    $display("%0d result words with %0d token ends; %0d mismatching or missing words.",
             n_results, n_tok_ends, fails);
    if (fails == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
